FILE: rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

	localparam int KIND_W = 1;
	localparam int CHAR_W = 8;
	localparam int INDEX_W = 11;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 16;
	localparam int COL_W = 7;
	localparam int LINE_W = 5;

	localparam logic [KIND_W-1:0] KIND_PUT = 1'b0;
	localparam logic [KIND_W-1:0] KIND_READ = 1'b1;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
	localparam logic [ATTR_W-1:0] FILL_ATTR = 8'h00;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_RESP
	} tcw_state_t;

endpackage

FILE: rtl/tcw_ifs.sv
// Handshake channel interfaces: request, response and attribute write.
interface tcw_req_if;
	import tcw_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0]  kind;
	logic [CHAR_W-1:0]  char_code;
	logic [INDEX_W-1:0] cell_index;
	modport source (output valid, kind, char_code, cell_index, input ready);
	modport sink (input valid, kind, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
	import tcw_pkg::*;
	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_value;
	logic [COL_W-1:0]  cursor_col;
	logic [LINE_W-1:0] cursor_line;
	logic              scrolled;
	modport source (output valid, cell_value, cursor_col, cursor_line, scrolled, input ready);
	modport sink (input valid, cell_value, cursor_col, cursor_line, scrolled, output ready);
endinterface

interface tcw_cfg_if;
	import tcw_pkg::*;
	logic              valid;
	logic              ready;
	logic [ATTR_W-1:0] text_attribute;
	modport source (output valid, text_attribute, input ready);
	modport sink (input valid, text_attribute, output ready);
endinterface

FILE: rtl/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/text_console_writer.sv
// Text console: screen RAM as a circular row buffer, cursor and scroll sequencer.
// One put or read at a time: taken in ST_IDLE, registered in ST_RESP once rsp is free.
// A put or newline that scrolls first clears the new bottom row (COLUMNS cells) in ST_CLEAR;
// scrolling moves the row base pointer, no screen copy.
// After reset a clearing pass writes COLUMNS*ROWS cells (2000 by default) to 0x0720,
// with req.ready low; attribute writes are taken at any time.
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic clk,
	input  logic arst_n,
	tcw_req_if.sink   req,
	tcw_rsp_if.source rsp,
	tcw_cfg_if.sink   cfg
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int SUM_W = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;
	localparam int CCOL_W = $clog2(COLUMNS);
	localparam int CROW_W = $clog2(ROWS);
	localparam logic [SUM_W-1:0] CELLS_S = SUM_W'(CELLS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
	localparam logic [CCOL_W-1:0] LAST_COL = CCOL_W'(COLUMNS - 1);
	localparam logic [CROW_W-1:0] LAST_ROW = CROW_W'(ROWS - 1);

	tcw_state_t state_q, state_d;

	logic [ATTR_W-1:0] attr_q;
	logic [ADDR_W-1:0] base_q;       // physical address of logical row 0
	logic [ADDR_W-1:0] row_start_q;  // physical address of the cursor row
	logic [ADDR_W-1:0] cur_addr_q;   // physical address of the cursor cell
	logic [CCOL_W-1:0] cur_col_q;
	logic [CROW_W-1:0] cur_row_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [CCOL_W-1:0] clr_cnt_q;
	logic              is_read_q;
	logic              oob_q;
	logic              scrolled_q;

	logic              out_valid_q;
	logic [CELL_W-1:0] out_value_q;
	logic [COL_W-1:0]  out_col_q;
	logic [LINE_W-1:0] out_line_q;
	logic              out_scrolled_q;

	// shared modular address adder
	logic [SUM_W-1:0]  add_a, add_b, add_sum;
	logic [ADDR_W-1:0] add_res;

	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;

	logic accept, line_step, last_row, load_rsp;

	assign add_sum = add_a + add_b;
	assign add_res = (add_sum >= CELLS_S) ? ADDR_W'(add_sum - CELLS_S) : ADDR_W'(add_sum);

	assign line_step = (req.char_code == NEWLINE_CODE) || (cur_col_q == LAST_COL);
	assign last_row = (cur_row_q == LAST_ROW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		add_a = '0;
		add_b = '0;
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_waddr = cur_addr_q;
		ram_wdata = {attr_q, req.char_code};
		accept = 1'b0;
		load_rsp = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				ram_we = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = {RESET_ATTR, SPACE_CODE};
				add_a = SUM_W'(clr_addr_q);
				add_b = SUM_W'(1);
				if (clr_addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					accept = 1'b1;
					state_d = ST_RESP;
					if (req.kind == KIND_READ) begin
						add_a = SUM_W'(req.cell_index);
						add_b = SUM_W'(base_q);
						ram_re = 1'b1;
					end else if (line_step) begin
						add_a = SUM_W'(row_start_q);
						add_b = SUM_W'(COLUMNS);
						ram_we = (req.char_code != NEWLINE_CODE);
						if (last_row) begin
							state_d = ST_CLEAR;
						end
					end else begin
						add_a = SUM_W'(cur_addr_q);
						add_b = SUM_W'(1);
						ram_we = 1'b1;
					end
				end
			end
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = {FILL_ATTR, SPACE_CODE};
				add_a = SUM_W'(clr_addr_q);
				add_b = SUM_W'(1);
				if (clr_cnt_q == LAST_COL) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			row_start_q <= '0;
			cur_addr_q <= '0;
			cur_col_q <= '0;
			cur_row_q <= '0;
			clr_addr_q <= '0;
			clr_cnt_q <= '0;
			is_read_q <= 1'b0;
			oob_q <= 1'b0;
			scrolled_q <= 1'b0;
		end else begin
			if (state_q == ST_INIT) begin
				clr_addr_q <= add_res;
			end
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= add_res;
				clr_cnt_q <= clr_cnt_q + 1'b1;
				// one past the cleared row is the new top row
				if (clr_cnt_q == LAST_COL) begin
					base_q <= add_res;
				end
			end
			if (accept) begin
				scrolled_q <= 1'b0;
				if (req.kind == KIND_READ) begin
					is_read_q <= 1'b1;
					oob_q <= !(SUM_W'(req.cell_index) < CELLS_S);
				end else begin
					is_read_q <= 1'b0;
					if (line_step) begin
						row_start_q <= add_res;
						cur_addr_q <= add_res;
						cur_col_q <= '0;
						if (last_row) begin
							// new bottom row lands on the old top row
							scrolled_q <= 1'b1;
							clr_addr_q <= add_res;
							clr_cnt_q <= '0;
						end else begin
							cur_row_q <= cur_row_q + 1'b1;
						end
					end else begin
						cur_addr_q <= add_res;
						cur_col_q <= cur_col_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (cfg.valid) begin
			attr_q <= cfg.text_attribute;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_rsp) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			out_value_q <= (is_read_q && !oob_q) ? ram_rdata : '0;
			out_col_q <= COL_W'(cur_col_q);
			out_line_q <= LINE_W'(cur_row_q);
			out_scrolled_q <= scrolled_q;
		end
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (add_res),
		.rdata (ram_rdata)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid = out_valid_q;
	assign rsp.cell_value = out_value_q;
	assign rsp.cursor_col = out_col_q;
	assign rsp.cursor_line = out_line_q;
	assign rsp.scrolled = out_scrolled_q;

endmodule
